// ===== rtl/awdc_pkg.sv =====
// ---------------------------------------------------------------------------
// awdc_pkg
// Shared types and constants of the anagram window distinct counter.
// ---------------------------------------------------------------------------
package awdc_pkg;

    localparam int          ALPHABET    = 26;
    localparam int          LETTER_W    = 5;
    localparam int          COUNT_OUT_W = 11;
    localparam int          MIS_W       = $clog2(ALPHABET + 1);
    localparam int          FP_W        = 64;
    localparam int          HALF_W      = FP_W / 2;
    localparam logic [63:0] BASE_RESET  = 64'd131;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_OLDSUB,
        S_NEWADD,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_BPUPD,
        S_FPADD,
        S_FPSUB,
        S_HWR,
        S_CHECK,
        S_SRCH,
        S_SRCH_CMP,
        S_RESULT
    } t_state;

    typedef enum logic [1:0] {
        BUMP_NONE,
        BUMP_NEEDLE,
        BUMP_WIN_ADD,
        BUMP_WIN_SUB
    } t_bump;

    typedef enum logic [1:0] {
        MSEL_BP,
        MSEL_FP,
        MSEL_OLD
    } t_msel;

    typedef enum logic [2:0] {
        MS_NONE,
        MS_P0,
        MS_P1,
        MS_P2,
        MS_P3
    } t_mstep;

    typedef enum logic [1:0] {
        FPOP_NONE,
        FPOP_BP,
        FPOP_ADD,
        FPOP_SUB
    } t_fpop;

    typedef struct packed {
        logic   latch_in;
        t_bump  bump;
        logic   len_inc;
        logic   pos_inc;
        logic   set_hay;
        logic   flag_long;
        logic   flag_full;
        logic   hist_rd;
        logic   hist_wr;
        t_msel  msel;
        t_mstep mstep;
        t_fpop  fpop;
        logic   set_match;
        logic   srch_clr;
        logic   srch_rd;
        logic   srch_inc;
        logic   insert;
        logic   load_out;
        logic   clear_job;
    } t_cmd;

    typedef struct packed {
        logic cmd;
        logic last;
        logic letter_ok;
        logic hay;
        logic len_zero;
        logic len_full;
        logic pos_lt_len;
        logic win_done;
        logic mis_zero;
        logic srch_more;
        logic hit;
        logic tbl_full;
        logic out_busy;
    } t_stat;

endpackage

// ===== rtl/awdc_ctrl.sv =====
// ---------------------------------------------------------------------------
// awdc_ctrl
// Sequencer: steps one word through histogram, fingerprint and table work.
// ---------------------------------------------------------------------------
module awdc_ctrl import awdc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_sts,
    output t_cmd  o_ctl,
    output logic  o_in_stall
);

    t_state r_state, n_state;
    t_msel  r_mop, n_mop;
    logic   r_full, n_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mop   <= MSEL_BP;
            r_full  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mop   <= n_mop;
            r_full  <= n_full;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_mop   = r_mop;
        n_full  = r_full;
        o_ctl   = '0;
        o_ctl.bump  = BUMP_NONE;
        o_ctl.msel  = r_mop;
        o_ctl.mstep = MS_NONE;
        o_ctl.fpop  = FPOP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.latch_in = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_sts.cmd) begin
                    n_state = i_sts.last ? S_RESULT : S_IDLE;
                    if (!i_sts.hay && i_sts.letter_ok) begin
                        if (i_sts.len_full) begin
                            o_ctl.flag_long = 1'b1;
                        end else begin
                            o_ctl.bump    = BUMP_NEEDLE;
                            o_ctl.len_inc = 1'b1;
                            n_mop   = MSEL_BP;
                            n_state = S_MUL0;
                        end
                    end
                end else begin
                    o_ctl.set_hay = 1'b1;
                    n_state = S_RESULT;
                    if (i_sts.letter_ok && !i_sts.len_zero) begin
                        if (i_sts.pos_lt_len) begin
                            o_ctl.bump    = BUMP_WIN_ADD;
                            o_ctl.pos_inc = 1'b1;
                            n_full  = 1'b0;
                            n_mop   = MSEL_FP;
                            n_state = S_MUL0;
                        end else begin
                            o_ctl.hist_rd = 1'b1;
                            n_full  = 1'b1;
                            n_state = S_OLDSUB;
                        end
                    end
                end
            end
            S_OLDSUB: begin
                o_ctl.bump = BUMP_WIN_SUB;
                n_state = S_NEWADD;
            end
            S_NEWADD: begin
                o_ctl.bump = BUMP_WIN_ADD;
                n_mop   = MSEL_FP;
                n_state = S_MUL0;
            end
            S_MUL0: begin
                o_ctl.mstep = MS_P0;
                n_state = S_MUL1;
            end
            S_MUL1: begin
                o_ctl.mstep = MS_P1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_ctl.mstep = MS_P2;
                n_state = S_MUL3;
            end
            S_MUL3: begin
                o_ctl.mstep = MS_P3;
                case (r_mop)
                    MSEL_BP:  n_state = S_BPUPD;
                    MSEL_FP:  n_state = S_FPADD;
                    MSEL_OLD: n_state = S_FPSUB;
                    default:  n_state = S_IDLE;
                endcase
            end
            S_BPUPD: begin
                o_ctl.fpop = FPOP_BP;
                n_state = i_sts.last ? S_RESULT : S_IDLE;
            end
            S_FPADD: begin
                o_ctl.fpop = FPOP_ADD;
                if (r_full) begin
                    n_mop   = MSEL_OLD;
                    n_state = S_MUL0;
                end else begin
                    n_state = S_HWR;
                end
            end
            S_FPSUB: begin
                o_ctl.fpop = FPOP_SUB;
                n_state = S_HWR;
            end
            S_HWR: begin
                o_ctl.hist_wr = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.win_done && i_sts.mis_zero) begin
                    o_ctl.set_match = 1'b1;
                    o_ctl.srch_clr  = 1'b1;
                    n_state = S_SRCH;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_SRCH: begin
                if (i_sts.srch_more) begin
                    o_ctl.srch_rd = 1'b1;
                    n_state = S_SRCH_CMP;
                end else begin
                    if (i_sts.tbl_full) begin
                        o_ctl.flag_full = 1'b1;
                    end else begin
                        o_ctl.insert = 1'b1;
                    end
                    n_state = S_RESULT;
                end
            end
            S_SRCH_CMP: begin
                if (i_sts.hit) begin
                    n_state = S_RESULT;
                end else begin
                    o_ctl.srch_inc = 1'b1;
                    n_state = S_SRCH;
                end
            end
            S_RESULT: begin
                if (!i_sts.out_busy) begin
                    o_ctl.load_out  = 1'b1;
                    o_ctl.clear_job = i_sts.last;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/awdc_dp.sv =====
// ---------------------------------------------------------------------------
// awdc_dp
// Datapath: histograms, letter ring, fingerprint arithmetic, seen table.
// ---------------------------------------------------------------------------
module awdc_dp import awdc_pkg::*; #(
    parameter int MAX_NEEDLE  = 64,
    parameter int TABLE_SLOTS = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd,
    input  logic [LETTER_W-1:0]    i_letter,
    input  logic                   i_last,
    input  logic                   i_cfg_we,
    input  logic [FP_W-1:0]        i_cfg_data,
    input  logic                   i_out_stall,
    input  t_cmd                   i_ctl,
    output t_stat                  o_sts,
    output logic                   o_out_valid,
    output logic                   o_window_match,
    output logic [COUNT_OUT_W-1:0] o_distinct_count,
    output logic                   o_table_full,
    output logic                   o_needle_too_long,
    output logic                   o_job_done
);

    localparam int LW = $clog2(MAX_NEEDLE + 1);
    localparam int RW = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
    localparam int TW = $clog2(TABLE_SLOTS + 1);
    localparam int IW = $clog2(TABLE_SLOTS);

    logic                r_cmd, r_letter_last;
    logic [LETTER_W-1:0] r_letter;
    logic [FP_W-1:0]     r_base;
    logic [LW-1:0]       r_ncnt [ALPHABET];
    logic [LW-1:0]       r_wcnt [ALPHABET];
    logic [MIS_W-1:0]    r_mis;
    logic [LW-1:0]       r_len, r_pos;
    logic [RW-1:0]       r_ring;
    logic                r_hay;
    logic [FP_W-1:0]     r_fp, r_bp, r_prod, r_acc;
    logic [LETTER_W-1:0] r_hist [MAX_NEEDLE];
    logic [LETTER_W-1:0] r_old;
    logic [FP_W-1:0]     r_seen [TABLE_SLOTS];
    logic [FP_W-1:0]     r_seen_q;
    logic [TW-1:0]       r_total, r_srch;
    logic                r_flag_full, r_flag_long, r_match;
    logic                r_out_valid, r_out_match, r_out_full, r_out_long, r_out_done;
    logic [COUNT_OUT_W-1:0] r_out_count;

    // Ring slot, wrapped against the current needle length.
    logic [LW-1:0] w_ring_ext, w_ring_eff, w_ring_inc, w_ring_nx;
    assign w_ring_ext = LW'(r_ring);
    assign w_ring_eff = (w_ring_ext >= r_len) ? '0 : w_ring_ext;
    assign w_ring_inc = w_ring_eff + 1'b1;
    assign w_ring_nx  = (w_ring_inc >= r_len) ? '0 : w_ring_inc;

    // One histogram update per cycle keeps the mismatch tally exact.
    logic [LETTER_W-1:0] w_bidx, w_bsel;
    logic                w_bok, w_before, w_after;
    logic [LW-1:0]       w_nc, w_wc, w_nn, w_wn;
    assign w_bidx = (i_ctl.bump == BUMP_WIN_SUB) ? r_old : r_letter;
    assign w_bok  = (i_ctl.bump != BUMP_NONE) && (w_bidx < LETTER_W'(ALPHABET));
    assign w_bsel = w_bok ? w_bidx : '0;
    assign w_nc   = r_ncnt[w_bsel];
    assign w_wc   = r_wcnt[w_bsel];

    always_comb begin
        w_nn = w_nc;
        w_wn = w_wc;
        case (i_ctl.bump)
            BUMP_NEEDLE:  w_nn = w_nc + 1'b1;
            BUMP_WIN_ADD: w_wn = w_wc + 1'b1;
            BUMP_WIN_SUB: w_wn = (w_wc != '0) ? w_wc - 1'b1 : w_wc;
            default:      w_wn = w_wc;
        endcase
    end
    assign w_before = (w_nc != w_wc);
    assign w_after  = (w_nn != w_wn);

    // Shared 32x32 multiplier, three partial products for a 64-bit product.
    logic [FP_W-1:0]   w_ma, w_mb, w_mp;
    logic [HALF_W-1:0] w_mx, w_my;
    always_comb begin
        case (i_ctl.msel)
            MSEL_BP:  begin w_ma = r_bp;              w_mb = r_base; end
            MSEL_FP:  begin w_ma = r_fp;              w_mb = r_base; end
            MSEL_OLD: begin w_ma = FP_W'(r_old);      w_mb = r_bp;   end
            default:  begin w_ma = r_fp;              w_mb = r_base; end
        endcase
    end
    assign w_mx = (i_ctl.mstep == MS_P2) ? w_ma[FP_W-1:HALF_W] : w_ma[HALF_W-1:0];
    assign w_my = (i_ctl.mstep == MS_P1) ? w_mb[FP_W-1:HALF_W] : w_mb[HALF_W-1:0];
    assign w_mp = w_mx * w_my;

    always_ff @(posedge i_clk) begin
        case (i_ctl.mstep)
            MS_P0: r_prod <= w_mp;
            MS_P1: begin
                r_acc  <= r_prod;
                r_prod <= w_mp;
            end
            MS_P2: begin
                r_acc  <= r_acc + {r_prod[HALF_W-1:0], {HALF_W{1'b0}}};
                r_prod <= w_mp;
            end
            MS_P3: r_acc <= r_acc + {r_prod[HALF_W-1:0], {HALF_W{1'b0}}};
            default: r_acc <= r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch_in) begin
            r_cmd         <= i_cmd;
            r_letter      <= i_letter;
            r_letter_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
        end else if (i_cfg_we) begin
            r_base <= i_cfg_data;
        end
    end

    // Job state, cleared by reset and after the last word's result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear_job) begin
            for (int k = 0; k < ALPHABET; k++) begin
                r_ncnt[k] <= '0;
                r_wcnt[k] <= '0;
            end
            r_mis       <= '0;
            r_len       <= '0;
            r_pos       <= '0;
            r_ring      <= '0;
            r_hay       <= 1'b0;
            r_fp        <= '0;
            r_bp        <= FP_W'(1);
            r_total     <= '0;
            r_flag_full <= 1'b0;
            r_flag_long <= 1'b0;
        end else begin
            if (w_bok) begin
                r_ncnt[w_bsel] <= w_nn;
                r_wcnt[w_bsel] <= w_wn;
                if (w_before && !w_after && r_mis != '0) begin
                    r_mis <= r_mis - 1'b1;
                end else if (!w_before && w_after) begin
                    r_mis <= r_mis + 1'b1;
                end
            end
            if (i_ctl.len_inc)   r_len <= r_len + 1'b1;
            if (i_ctl.pos_inc)   r_pos <= r_pos + 1'b1;
            if (i_ctl.set_hay)   r_hay <= 1'b1;
            if (i_ctl.flag_long) r_flag_long <= 1'b1;
            if (i_ctl.flag_full) r_flag_full <= 1'b1;
            if (i_ctl.hist_wr)   r_ring <= w_ring_nx[RW-1:0];
            if (i_ctl.insert)    r_total <= r_total + 1'b1;
            case (i_ctl.fpop)
                FPOP_BP:  r_bp <= r_acc;
                FPOP_ADD: r_fp <= r_acc + FP_W'(r_letter);
                FPOP_SUB: r_fp <= r_fp - r_acc;
                default:  r_fp <= r_fp;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.hist_wr) begin
            r_hist[w_ring_eff[RW-1:0]] <= r_letter;
        end
        if (i_ctl.hist_rd) begin
            r_old <= r_hist[w_ring_eff[RW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.insert) begin
            r_seen[r_total[IW-1:0]] <= r_fp;
        end
        if (i_ctl.srch_rd) begin
            r_seen_q <= r_seen[r_srch[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.srch_clr) begin
            r_srch <= '0;
        end else if (i_ctl.srch_inc) begin
            r_srch <= r_srch + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.latch_in) begin
            r_match <= 1'b0;
        end else if (i_ctl.set_match) begin
            r_match <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_out_match <= r_match;
            r_out_count <= COUNT_OUT_W'(r_total);
            r_out_full  <= r_flag_full;
            r_out_long  <= r_flag_long;
            r_out_done  <= r_letter_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_window_match    = r_out_match;
    assign o_distinct_count  = r_out_count;
    assign o_table_full      = r_out_full;
    assign o_needle_too_long = r_out_long;
    assign o_job_done        = r_out_done;

    always_comb begin
        o_sts.cmd        = r_cmd;
        o_sts.last       = r_letter_last;
        o_sts.letter_ok  = (r_letter < LETTER_W'(ALPHABET));
        o_sts.hay        = r_hay;
        o_sts.len_zero   = (r_len == '0);
        o_sts.len_full   = (r_len >= LW'(MAX_NEEDLE));
        o_sts.pos_lt_len = (r_pos < r_len);
        o_sts.win_done   = (r_pos == r_len);
        o_sts.mis_zero   = (r_mis == '0);
        o_sts.srch_more  = (r_srch < r_total);
        o_sts.hit        = (r_seen_q == r_fp);
        o_sts.tbl_full   = (r_total >= TW'(TABLE_SLOTS));
        o_sts.out_busy   = r_out_valid && i_out_stall;
    end

endmodule

// ===== rtl/anagram_window_distinct_counter_core.sv =====
// ---------------------------------------------------------------------------
// anagram_window_distinct_counter_core
// Sliding-window anagram matcher that counts distinct matching windows.
// ---------------------------------------------------------------------------
//
//   channel   | direction | handshake                  | payload
//   ----------+-----------+----------------------------+---------------------------
//   in        | sink      | i_in_valid / o_in_stall    | i_cmd, i_letter, i_last
//   out       | source    | o_out_valid / i_out_stall  | o_window_match,
//             |           |                            | o_distinct_count, flags,
//             |           |                            | o_job_done
//   cfg       | sink      | i_cfg_we                   | i_cfg_data (base)
//
// A needle word is worked with one 64-bit product, a haystack word while the
// window fills with one as well, and one with a full window with two products.
// A matching window adds a scan of the up to TABLE_SLOTS stored entries of the
// seen table, one entry at a time; the shared 32x32 multiplier and the single
// read port of the table make the work serial. Reset is synchronous, active low,
// and needs no clearing pass. A stalled result sits in the output register
// while the next word is taken and worked; only its own result waits.
//
module anagram_window_distinct_counter_core import awdc_pkg::*; #(
    parameter int MAX_NEEDLE  = 64,
    parameter int TABLE_SLOTS = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_cmd,
    input  logic [LETTER_W-1:0]    i_letter,
    input  logic                   i_last,
    input  logic                   i_cfg_we,
    input  logic [FP_W-1:0]        i_cfg_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_window_match,
    output logic [COUNT_OUT_W-1:0] o_distinct_count,
    output logic                   o_table_full,
    output logic                   o_needle_too_long,
    output logic                   o_job_done
);

    // The controller sequences each word; the datapath owns all job state.
    t_cmd  w_ctl;
    t_stat w_sts;

    awdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl),
        .o_in_stall (o_in_stall)
    );

    awdc_dp #(
        .MAX_NEEDLE  (MAX_NEEDLE),
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (i_cmd),
        .i_letter          (i_letter),
        .i_last            (i_last),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_out_stall       (i_out_stall),
        .i_ctl             (w_ctl),
        .o_sts             (w_sts),
        .o_out_valid       (o_out_valid),
        .o_window_match    (o_window_match),
        .o_distinct_count  (o_distinct_count),
        .o_table_full      (o_table_full),
        .o_needle_too_long (o_needle_too_long),
        .o_job_done        (o_job_done)
    );

endmodule

// ===== rtl/awdc_chk.sv =====
// ---------------------------------------------------------------------------
// awdc_chk
// Port-level checks of the anagram window distinct counter.
// ---------------------------------------------------------------------------
module awdc_chk import awdc_pkg::*; #(
    parameter int TABLE_SLOTS = 1024
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input logic                   i_cmd,
    input logic [LETTER_W-1:0]    i_letter,
    input logic                   i_last,
    input logic                   i_cfg_we,
    input logic [FP_W-1:0]        i_cfg_data,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic                   o_window_match,
    input logic [COUNT_OUT_W-1:0] o_distinct_count,
    input logic                   o_table_full,
    input logic                   o_needle_too_long,
    input logic                   o_job_done
);

    // Nothing comes out in the first cycle after reset is released.
    a_reset_quiet: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_out_valid)
        else $error("result shown right after reset");

    // Every word passes through more states than idle, so intake closes after a word.
    a_intake_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word taken back to back");

    // A dropped fingerprint only happens with the table at capacity.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_table_full |-> o_distinct_count == COUNT_OUT_W'(TABLE_SLOTS))
        else $error("table full flagged below capacity");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_distinct_count)
            && $stable(o_window_match) && $stable(o_job_done))
        else $error("stalled result changed");

endmodule

bind anagram_window_distinct_counter_core awdc_chk #(
    .TABLE_SLOTS (TABLE_SLOTS)
) u_awdc_chk (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the anagram window distinct counter. A behavioral
// model of the block predicts every result word from the accepted input
// words and the fingerprint base it has written. Each result word from the
// block is compared field by field with the oldest prediction. Both sides of
// the block idle and stall at random, with some stretches where they do not.
// ---------------------------------------------------------------------------
module tb_top;
    import awdc_pkg::*;

    localparam int MAX_LEN = 64;
    localparam int SLOTS   = 1024;

    // The two command codes of an input word.
    localparam bit CMD_NEEDLE = 1'b0;
    localparam bit CMD_HAY    = 1'b1;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic                   i_cmd;
    logic [LETTER_W-1:0]    i_letter;
    logic                   i_last;
    logic                   i_cfg_we;
    logic [FP_W-1:0]        i_cfg_data;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic                   o_window_match;
    logic [COUNT_OUT_W-1:0] o_distinct_count;
    logic                   o_table_full;
    logic                   o_needle_too_long;
    logic                   o_job_done;

    anagram_window_distinct_counter_core #(
        .MAX_NEEDLE (MAX_LEN),
        .TABLE_SLOTS(SLOTS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_letter         (i_letter),
        .i_last           (i_last),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_window_match   (o_window_match),
        .o_distinct_count (o_distinct_count),
        .o_table_full     (o_table_full),
        .o_needle_too_long(o_needle_too_long),
        .o_job_done       (o_job_done)
    );

    // One predicted result word.
    typedef struct {
        bit                   window_match;
        bit [COUNT_OUT_W-1:0] distinct_count;
        bit                   table_full;
        bit                   needle_too_long;
        bit                   job_done;
    } t_outcome;

    t_outcome pending_outcomes[$];

    // Model state of the block, kept in step with the accepted words.
    logic [63:0] cur_base;
    int          needle_hist[ALPHABET];
    int          window_hist[ALPHABET];
    int          unequal_letters;
    int          needle_len;
    int          hay_pos;
    int          ring_ptr;
    bit          hay_started;
    logic [4:0]  ring_letters[MAX_LEN];
    logic [63:0] window_fp;
    logic [63:0] top_power;
    logic [63:0] seen_fps[$];
    bit          table_overflow;
    bit          needle_overflow;

    // Run statistics and the quiet switch that turns off random idling.
    int words_sent;
    int words_checked;
    int matches_seen;
    int error_count;
    bit quiet;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // A generous ceiling: the slowest correct run is far below this.
    initial begin
        #4000000;
        $display("[anagram_window_distinct_counter_core] ERROR");
        $finish;
    end

    function automatic void clear_model();
        for (int k = 0; k < ALPHABET; k++) begin
            needle_hist[k] = 0;
            window_hist[k] = 0;
        end
        unequal_letters = 0;
        needle_len      = 0;
        hay_pos         = 0;
        ring_ptr        = 0;
        hay_started     = 1'b0;
        window_fp       = '0;
        top_power       = 64'd1;
        seen_fps.delete();
        table_overflow  = 1'b0;
        needle_overflow = 1'b0;
    endfunction

    // Moves one letter's needle or window count and keeps the tally of
    // letters whose two counts disagree up to date.
    function automatic void adjust_count(int x, int dn, int dw);
        bit was_unequal;
        bit now_unequal;
        was_unequal = needle_hist[x] != window_hist[x];
        if (dn > 0) needle_hist[x]++;
        if (dw > 0) window_hist[x]++;
        if (dw < 0 && window_hist[x] > 0) window_hist[x]--;
        now_unequal = needle_hist[x] != window_hist[x];
        if (was_unequal && !now_unequal && unequal_letters > 0) unequal_letters--;
        if (!was_unequal && now_unequal) unequal_letters++;
    endfunction

    function automatic void record_fingerprint(logic [63:0] fp);
        foreach (seen_fps[k]) begin
            if (seen_fps[k] == fp) return;
        end
        if (seen_fps.size() >= SLOTS) begin
            table_overflow = 1'b1;
            return;
        end
        seen_fps.push_back(fp);
    endfunction

    // Applies one accepted word to the model and queues its result, if any.
    function automatic void predict_word(bit cmd, logic [4:0] c, bit last);
        bit       in_range;
        bit       hit;
        int       old;
        t_outcome res;
        in_range = c < ALPHABET;
        hit      = 1'b0;
        if (cmd == CMD_NEEDLE) begin
            if (!hay_started && in_range) begin
                if (needle_len >= MAX_LEN) begin
                    needle_overflow = 1'b1;
                end else begin
                    adjust_count(c, 1, 0);
                    needle_len++;
                    top_power = top_power * cur_base;
                end
            end
            if (!last) return;
        end else begin
            hay_started = 1'b1;
            if (in_range && needle_len > 0) begin
                if (ring_ptr >= needle_len) ring_ptr = 0;
                if (hay_pos < needle_len) begin
                    adjust_count(c, 0, 1);
                    window_fp = window_fp * cur_base + 64'(c);
                    hay_pos++;
                end else begin
                    old = ring_letters[ring_ptr];
                    adjust_count(old, 0, -1);
                    adjust_count(c, 0, 1);
                    window_fp = window_fp * cur_base + 64'(c) - 64'(old) * top_power;
                end
                ring_letters[ring_ptr] = c;
                ring_ptr++;
                if (ring_ptr >= needle_len) ring_ptr = 0;
                if (hay_pos == needle_len && unequal_letters == 0) begin
                    hit = 1'b1;
                    record_fingerprint(window_fp);
                end
            end
        end
        res.window_match    = hit;
        res.distinct_count  = COUNT_OUT_W'(seen_fps.size());
        res.table_full      = table_overflow;
        res.needle_too_long = needle_overflow;
        res.job_done        = last;
        pending_outcomes.push_back(res);
        if (last) clear_model();
    endfunction

    // Sends one word. Valid stays high after acceptance so that back-to-back
    // words need no drop; anything that pauses calls release_input first.
    task automatic send_word(bit cmd, logic [4:0] c, bit last);
        int gap;
        gap = 0;
        if (!quiet) begin
            while ($urandom_range(99) < 23) gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_letter   <= c;
        i_last     <= last;
        do @(posedge i_clk); while (o_in_stall);
        predict_word(cmd, c, last);
        words_sent++;
    endtask

    task automatic release_input();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until every predicted word has come back, then lets the block
    // finish any needle word still in flight, which yields no result.
    task automatic wait_drained();
        release_input();
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_base(logic [63:0] value);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_base = value;
    endtask

    task automatic send_needle(string s);
        foreach (s[k]) send_word(CMD_NEEDLE, 5'(s[k] - "a"), 1'b0);
    endtask

    // Sends a haystack; the final letter carries the end-of-job mark when close_job is set.
    task automatic send_haystack(string s, bit close_job);
        foreach (s[k]) send_word(CMD_HAY, 5'(s[k] - "a"), close_job && k == s.len() - 1);
    endtask

    // Result side: random stalls and the field-by-field comparison.
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(99) < 23);
            if (o_out_valid && !i_out_stall) begin
                words_checked++;
                if (o_window_match) matches_seen++;
                if (pending_outcomes.size() == 0) begin
                    $error("result word with no prediction waiting");
                    error_count++;
                end else begin
                    want = pending_outcomes.pop_front();
                    if (o_window_match !== want.window_match) begin
                        $error("window_match: expected %0d, got %0d",
                               want.window_match, o_window_match);
                        error_count++;
                    end
                    if (o_distinct_count !== want.distinct_count) begin
                        $error("distinct_count: expected %0d, got %0d",
                               want.distinct_count, o_distinct_count);
                        error_count++;
                    end
                    if (o_table_full !== want.table_full) begin
                        $error("table_full: expected %0d, got %0d",
                               want.table_full, o_table_full);
                        error_count++;
                    end
                    if (o_needle_too_long !== want.needle_too_long) begin
                        $error("needle_too_long: expected %0d, got %0d",
                               want.needle_too_long, o_needle_too_long);
                        error_count++;
                    end
                    if (o_job_done !== want.job_done) begin
                        $error("job_done: expected %0d, got %0d",
                               want.job_done, o_job_done);
                        error_count++;
                    end
                end
            end
        end
    end

    // Overlapping anagrams, repeated windows, letters outside the alphabet,
    // the alphabet ends, and a needle word arriving after the haystack began.
    task automatic test_basic_jobs();
        send_needle("abz");
        send_haystack("zbazab", 1'b0);
        send_word(CMD_HAY, 5'd31, 1'b0);
        send_word(CMD_NEEDLE, 5'd0, 1'b0);
        send_word(CMD_HAY, 5'd26, 1'b0);
        send_haystack("abzba", 1'b1);
        // A needle word outside the alphabet is ignored.
        send_word(CMD_NEEDLE, 5'd30, 1'b0);
        send_needle("aa");
        send_haystack("aaaa", 1'b1);
    endtask

    // An empty needle, a short haystack, and a job closed by a needle word.
    task automatic test_degenerate_jobs();
        send_haystack("abc", 1'b1);
        send_needle("abcd");
        send_haystack("dcb", 1'b1);
        send_needle("xy");
        send_word(CMD_NEEDLE, 5'd25, 1'b1);
    endtask

    // A needle beyond the maximum length is cut short and flagged.
    task automatic test_long_needle();
        for (int k = 0; k < MAX_LEN + 3; k++) send_word(CMD_NEEDLE, 5'(k % 2), 1'b0);
        for (int k = 0; k < MAX_LEN + 4; k++) send_word(CMD_HAY, 5'(k % 2), k == MAX_LEN + 3);
    endtask

    // The base at its extremes, and a base change in the middle of a needle.
    task automatic test_base_settings();
        write_base(64'd2);
        send_needle("ba");
        send_haystack("abab", 1'b1);
        write_base('1);
        send_needle("cab");
        send_haystack("bcabcaz", 1'b1);
        send_needle("pq");
        write_base({$urandom(), $urandom()});
        send_needle("r");
        send_haystack("rqpqrp", 1'b1);
        write_base(64'd131);
    endtask

    // Random jobs: haystacks drawn mostly from the letters of the needle
    // so that windows match often, with noise letters and stray needle words.
    task automatic test_random_jobs(int words);
        logic [4:0] pool[$];
        logic [4:0] c;
        int         len;
        int         hay_len;
        int         job;
        int         start;
        start = words_sent;
        job   = 0;
        while (words_sent - start < words) begin
            job++;
            quiet = (job >= 8 && job < 14);
            if (job % 9 == 0) write_base(64'($urandom_range(2, 1000)));
            if (job % 5 == 0) wait_drained();
            len = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
            pool.delete();
            for (int k = 0; k < len; k++) begin
                c = 5'($urandom_range(ALPHABET - 1));
                if (k > 0 && $urandom_range(2) == 0) c = pool[0];
                pool.push_back(c);
                send_word(CMD_NEEDLE, c, 1'b0);
            end
            if ($urandom_range(7) == 0) send_word(CMD_NEEDLE, 5'($urandom_range(31)), 1'b0);
            hay_len = $urandom_range(len, 4 * len + 6);
            for (int k = 0; k < hay_len; k++) begin
                if ($urandom_range(9) == 0) c = 5'($urandom_range(31));
                else c = pool[$urandom_range(len - 1)];
                if ($urandom_range(19) == 0) send_word(CMD_NEEDLE, c, 1'b0);
                send_word(CMD_HAY, c, k == hay_len - 1);
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_cmd       = 1'b0;
        i_letter    = '0;
        i_last      = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        i_out_stall = 1'b0;
        quiet       = 1'b0;
        words_sent  = 0;
        words_checked = 0;
        matches_seen  = 0;
        error_count   = 0;
        cur_base    = BASE_RESET;
        clear_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_jobs();
        test_degenerate_jobs();
        test_long_needle();
        test_base_settings();
        test_random_jobs(260);

        release_input();
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Sent %0d words, checked %0d result words, %0d of them matching windows.",
                 words_sent, words_checked, matches_seen);
        $display("Covered base extremes, a mid-needle base change and an overlong needle.");
        if (error_count == 0) begin
            $display("[anagram_window_distinct_counter_core] OK");
        end else begin
            $display("[anagram_window_distinct_counter_core] ERROR");
        end
        $finish;
    end

endmodule
